[src/first_fit_segment_allocator_unit_defines.svh]
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define FFSA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FFSA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/ffsa_pkg.sv]
// Shared types and codes of the segment allocator.
package ffsa_pkg;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_HEAP_FULL  = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } status_t;

    typedef enum logic {
        ACT_ALLOC   = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_LOAD = 2'd1,
        CELL_PREV = 2'd2,
        CELL_NEXT = 2'd3
    } cell_op_t;

    typedef enum logic [2:0] {
        FSM_IDLE    = 3'd0,
        FSM_SCAN    = 3'd1,
        FSM_COMPACT = 3'd2,
        FSM_FINISH  = 3'd3,
        FSM_DONE    = 3'd4
    } fsm_t;

endpackage

[src/ffsa_if.sv]
// Command and response channel interfaces.
interface ffsa_cmd_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [8:0] req_size;
    logic [7:0] release_start;
    modport source (output valid, action, req_size, release_start, input ready);
    modport sink   (input valid, action, req_size, release_start, output ready);
endinterface

interface ffsa_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] slot_start;
    logic [1:0] status;
    logic       compacted;
    modport source (output valid, slot_start, status, compacted, input ready);
    modport sink   (input valid, slot_start, status, compacted, output ready);
endinterface

[src/first_fit_segment_allocator_unit.sv]
// First-fit segment allocator: descriptor chain and scan/compact sequencer.
//
//  channel | role | fields
//  cmd     | sink | action, req_size, release_start
//  rsp     | src  | slot_start, status, compacted
//
// One command at a time. A scan visits one descriptor per cycle; a compaction
// visits each descriptor once more, then takes one finish step. Insert and
// delete shift all following cells of the chain together.
// Reset loads the chain with one free segment covering the heap.
// A waiting response stalls only the final hand-off; a new command is taken
// as soon as the sequencer is idle.
`include "first_fit_segment_allocator_unit_defines.svh"
module first_fit_segment_allocator_unit #(
    parameter int HEAP_SLOTS   = 256,
    parameter int MAX_SEGMENTS = 32
) (
    input logic             clk,
    input logic             rst_n,
    ffsa_cmd_if.sink        cmd,
    ffsa_rsp_if.source      rsp
);

    localparam int SW = (HEAP_SLOTS > 1) ? $clog2(HEAP_SLOTS) : 1;
    localparam int LW = $clog2(HEAP_SLOTS + 1);
    localparam int CW = ((LW > 9) ? LW : 9) + 1;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int NW = $clog2(MAX_SEGMENTS + 1);

    // Chain wiring
    ffsa_pkg::cell_op_t cell_op [MAX_SEGMENTS];
    logic               ld_used [MAX_SEGMENTS];
    logic [SW-1:0]      ld_start[MAX_SEGMENTS];
    logic [LW-1:0]      ld_len  [MAX_SEGMENTS];
    logic               q_used  [MAX_SEGMENTS];
    logic [SW-1:0]      q_start [MAX_SEGMENTS];
    logic [LW-1:0]      q_len   [MAX_SEGMENTS];

    for (genvar k = 0; k < MAX_SEGMENTS; k++)
    begin : g_cell
        logic          p_used, n_used;
        logic [SW-1:0] p_start, n_start;
        logic [LW-1:0] p_len, n_len;
        if (k == 0)
        begin : g_first
            assign p_used  = 1'b0;
            assign p_start = '0;
            assign p_len   = '0;
        end
        else
        begin : g_mid
            assign p_used  = q_used[k-1];
            assign p_start = q_start[k-1];
            assign p_len   = q_len[k-1];
        end
        if (k == MAX_SEGMENTS - 1)
        begin : g_last
            assign n_used  = 1'b0;
            assign n_start = '0;
            assign n_len   = '0;
        end
        else
        begin : g_tail
            assign n_used  = q_used[k+1];
            assign n_start = q_start[k+1];
            assign n_len   = q_len[k+1];
        end
        ffsa_cell #(
            .SW      (SW),
            .LW      (LW),
            .RST_LEN ((k == 0) ? HEAP_SLOTS : 0)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (cell_op[k]),
            .ld_used    (ld_used[k]),
            .ld_start   (ld_start[k]),
            .ld_len     (ld_len[k]),
            .prev_used  (p_used),
            .prev_start (p_start),
            .prev_len   (p_len),
            .next_used  (n_used),
            .next_start (n_start),
            .next_len   (n_len),
            .used       (q_used[k]),
            .start      (q_start[k]),
            .len        (q_len[k])
        );
    end

    // Sequencer registers
    ffsa_pkg::fsm_t      state_reg, state_next;
    logic [NW-1:0]       count_reg, count_next;
    logic [NW-1:0]       idx_reg, idx_next;
    logic                act_reg, act_next;
    logic [8:0]          req_reg, req_next;
    logic [7:0]          rel_reg, rel_next;
    logic [LW-1:0]       end_reg, end_next;
    logic [LW-1:0]       pool_reg, pool_next;
    logic [SW-1:0]       res_slot_reg, res_slot_next;
    ffsa_pkg::status_t   res_st_reg, res_st_next;
    logic                res_comp_reg, res_comp_next;
    logic                ov_reg, ov_next;
    logic [7:0]          o_slot_reg, o_slot_next;
    ffsa_pkg::status_t   o_st_reg, o_st_next;
    logic                o_comp_reg, o_comp_next;

    // Descriptor under the scan pointer
    logic [IW-1:0] rd_idx;
    logic          rd_used;
    logic [SW-1:0] rd_start;
    logic [LW-1:0] rd_len;
    logic [CW-1:0] req_x, len_x, end_req;
    logic [IW-1:0] cnt_idx, cnt_idx1;
    logic          scan_done, tail_ok;

    assign rd_idx   = idx_reg[IW-1:0];
    assign rd_used  = q_used[rd_idx];
    assign rd_start = q_start[rd_idx];
    assign rd_len   = q_len[rd_idx];
    assign req_x    = CW'(req_reg);
    assign len_x    = CW'(rd_len);
    assign end_req  = CW'(end_reg) + req_x;
    assign cnt_idx  = count_reg[IW-1:0];
    assign cnt_idx1 = IW'(count_reg + NW'(1));
    assign scan_done = (idx_reg >= count_reg);
    assign tail_ok  = (pool_reg != '0) && (count_reg < NW'(MAX_SEGMENTS));

    assign cmd.ready      = (state_reg == ffsa_pkg::FSM_IDLE);
    assign rsp.valid      = ov_reg;
    assign rsp.slot_start = o_slot_reg;
    assign rsp.status     = o_st_reg;
    assign rsp.compacted  = o_comp_reg;

    // Next state, chain control and results
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        act_next      = act_reg;
        req_next      = req_reg;
        rel_next      = rel_reg;
        end_next      = end_reg;
        pool_next     = pool_reg;
        res_slot_next = res_slot_reg;
        res_st_next   = res_st_reg;
        res_comp_next = res_comp_reg;
        ov_next       = ov_reg && !rsp.ready;
        o_slot_next   = o_slot_reg;
        o_st_next     = o_st_reg;
        o_comp_next   = o_comp_reg;
        for (int k = 0; k < MAX_SEGMENTS; k++)
        begin
            cell_op[k]  = ffsa_pkg::CELL_HOLD;
            ld_used[k]  = 1'b0;
            ld_start[k] = '0;
            ld_len[k]   = '0;
        end

        unique case (state_reg)
            ffsa_pkg::FSM_IDLE:
            begin
                if (cmd.valid)
                begin
                    act_next      = cmd.action;
                    req_next      = cmd.req_size;
                    rel_next      = cmd.release_start;
                    idx_next      = '0;
                    res_comp_next = 1'b0;
                    if (cmd.action == ffsa_pkg::ACT_ALLOC && cmd.req_size == '0)
                    begin
                        res_slot_next = '0;
                        res_st_next   = ffsa_pkg::ST_HEAP_FULL;
                        state_next    = ffsa_pkg::FSM_DONE;
                    end
                    else
                    begin
                        state_next = ffsa_pkg::FSM_SCAN;
                    end
                end
            end

            ffsa_pkg::FSM_SCAN:
            begin
                if (act_reg == ffsa_pkg::ACT_RELEASE)
                begin
                    if (scan_done)
                    begin
                        res_slot_next = '0;
                        res_st_next   = ffsa_pkg::ST_NOT_FOUND;
                        state_next    = ffsa_pkg::FSM_DONE;
                    end
                    else if (rd_used && CW'(rd_start) == CW'(rel_reg))
                    begin
                        cell_op[rd_idx] = ffsa_pkg::CELL_LOAD;
                        ld_used[rd_idx] = 1'b0;
                        ld_start[rd_idx] = rd_start;
                        ld_len[rd_idx]  = rd_len;
                        res_slot_next   = rd_start;
                        res_st_next     = ffsa_pkg::ST_OK;
                        state_next      = ffsa_pkg::FSM_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + NW'(1);
                    end
                end
                else if (scan_done)
                begin
                    // No fit: start repacking
                    idx_next   = '0;
                    end_next   = '0;
                    pool_next  = '0;
                    state_next = ffsa_pkg::FSM_COMPACT;
                end
                else if (!rd_used && len_x >= req_x)
                begin
                    state_next = ffsa_pkg::FSM_DONE;
                    if (len_x == req_x)
                    begin
                        cell_op[rd_idx]  = ffsa_pkg::CELL_LOAD;
                        ld_used[rd_idx]  = 1'b1;
                        ld_start[rd_idx] = rd_start;
                        ld_len[rd_idx]   = rd_len;
                        res_slot_next    = rd_start;
                        res_st_next      = ffsa_pkg::ST_OK;
                    end
                    else if (count_reg >= NW'(MAX_SEGMENTS))
                    begin
                        res_slot_next = '0;
                        res_st_next   = ffsa_pkg::ST_TABLE_FULL;
                    end
                    else
                    begin
                        // Split: used part here, free remainder in the next cell
                        for (int k = 0; k < MAX_SEGMENTS; k++)
                        begin
                            if (k == int'(idx_reg))
                            begin
                                cell_op[k]  = ffsa_pkg::CELL_LOAD;
                                ld_used[k]  = 1'b1;
                                ld_start[k] = rd_start;
                                ld_len[k]   = LW'(req_x);
                            end
                            else if (k == int'(idx_reg) + 1)
                            begin
                                cell_op[k]  = ffsa_pkg::CELL_LOAD;
                                ld_used[k]  = 1'b0;
                                ld_start[k] = SW'(CW'(rd_start) + req_x);
                                ld_len[k]   = LW'(len_x - req_x);
                            end
                            else if (k > int'(idx_reg) + 1)
                            begin
                                cell_op[k] = ffsa_pkg::CELL_PREV;
                            end
                        end
                        count_next    = count_reg + NW'(1);
                        res_slot_next = rd_start;
                        res_st_next   = ffsa_pkg::ST_OK;
                    end
                end
                else
                begin
                    idx_next = idx_reg + NW'(1);
                end
            end

            ffsa_pkg::FSM_COMPACT:
            begin
                if (scan_done)
                begin
                    state_next = ffsa_pkg::FSM_FINISH;
                end
                else if (rd_used)
                begin
                    // Move used segment down to the running end
                    cell_op[rd_idx]  = ffsa_pkg::CELL_LOAD;
                    ld_used[rd_idx]  = 1'b1;
                    ld_start[rd_idx] = SW'(end_reg);
                    ld_len[rd_idx]   = rd_len;
                    end_next         = end_reg + rd_len;
                    idx_next         = idx_reg + NW'(1);
                end
                else
                begin
                    // Drop free segment into the pool and close the gap
                    for (int k = 0; k < MAX_SEGMENTS; k++)
                    begin
                        if (k >= int'(idx_reg))
                        begin
                            cell_op[k] = ffsa_pkg::CELL_NEXT;
                        end
                    end
                    pool_next  = pool_reg + rd_len;
                    count_next = count_reg - NW'(1);
                end
            end

            ffsa_pkg::FSM_FINISH:
            begin
                res_comp_next = 1'b1;
                state_next    = ffsa_pkg::FSM_DONE;
                res_slot_next = '0;
                if (end_req >= CW'(HEAP_SLOTS) ||
                    ({1'b0, count_reg} + (NW+1)'(2)) > (NW+1)'(MAX_SEGMENTS))
                begin
                    res_st_next = (end_req >= CW'(HEAP_SLOTS)) ?
                                  ffsa_pkg::ST_HEAP_FULL : ffsa_pkg::ST_TABLE_FULL;
                    if (tail_ok)
                    begin
                        cell_op[cnt_idx]  = ffsa_pkg::CELL_LOAD;
                        ld_used[cnt_idx]  = 1'b0;
                        ld_start[cnt_idx] = SW'(end_reg);
                        ld_len[cnt_idx]   = pool_reg;
                        count_next        = count_reg + NW'(1);
                    end
                end
                else
                begin
                    cell_op[cnt_idx]   = ffsa_pkg::CELL_LOAD;
                    ld_used[cnt_idx]   = 1'b1;
                    ld_start[cnt_idx]  = SW'(end_reg);
                    ld_len[cnt_idx]    = LW'(req_x);
                    cell_op[cnt_idx1]  = ffsa_pkg::CELL_LOAD;
                    ld_used[cnt_idx1]  = 1'b0;
                    ld_start[cnt_idx1] = SW'(end_req);
                    ld_len[cnt_idx1]   = LW'(CW'(HEAP_SLOTS) - end_req);
                    count_next         = count_reg + NW'(2);
                    res_slot_next      = SW'(end_reg);
                    res_st_next        = ffsa_pkg::ST_OK;
                end
            end

            ffsa_pkg::FSM_DONE:
            begin
                // Hand the word to the output register once it is free
                if (!ov_reg || rsp.ready)
                begin
                    ov_next     = 1'b1;
                    o_slot_next = 8'(res_slot_reg);
                    o_st_next   = res_st_reg;
                    o_comp_next = res_comp_reg;
                    state_next  = ffsa_pkg::FSM_IDLE;
                end
            end

            default:
            begin
                state_next = ffsa_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffsa_pkg::FSM_IDLE;
            count_reg <= NW'(1);
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        req_reg      <= req_next;
        rel_reg      <= rel_next;
        end_reg      <= end_next;
        pool_reg     <= pool_next;
        res_slot_reg <= res_slot_next;
        res_st_reg   <= res_st_next;
        res_comp_reg <= res_comp_next;
        o_slot_reg   <= o_slot_next;
        o_st_reg     <= o_st_next;
        o_comp_reg   <= o_comp_next;
    end

    // Checks
    `FFSA_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= NW'(MAX_SEGMENTS))
    `FFSA_ASSERT_NEXT(a_compact_shrinks, clk, rst_n, state_reg == ffsa_pkg::FSM_COMPACT, count_reg <= $past(count_reg))
    `FFSA_ASSERT_IMPL(a_err_slot_zero, clk, rst_n, ov_reg && o_st_reg != ffsa_pkg::ST_OK, o_slot_reg == 8'd0)

endmodule

[src/ffsa_cell.sv]
// One segment descriptor cell of the descriptor chain.
module ffsa_cell #(
    parameter int SW      = 8,
    parameter int LW      = 9,
    parameter int RST_LEN = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ffsa_pkg::cell_op_t op,
    input  logic              ld_used,
    input  logic [SW-1:0]     ld_start,
    input  logic [LW-1:0]     ld_len,
    input  logic              prev_used,
    input  logic [SW-1:0]     prev_start,
    input  logic [LW-1:0]     prev_len,
    input  logic              next_used,
    input  logic [SW-1:0]     next_start,
    input  logic [LW-1:0]     next_len,
    output logic              used,
    output logic [SW-1:0]     start,
    output logic [LW-1:0]     len
);

    logic          used_reg, used_next;
    logic [SW-1:0] start_reg, start_next;
    logic [LW-1:0] len_reg, len_next;

    // Select load, shift from a neighbor, or hold
    always_comb
    begin
        used_next  = used_reg;
        start_next = start_reg;
        len_next   = len_reg;
        unique case (op)
            ffsa_pkg::CELL_LOAD:
            begin
                used_next  = ld_used;
                start_next = ld_start;
                len_next   = ld_len;
            end
            ffsa_pkg::CELL_PREV:
            begin
                used_next  = prev_used;
                start_next = prev_start;
                len_next   = prev_len;
            end
            ffsa_pkg::CELL_NEXT:
            begin
                used_next  = next_used;
                start_next = next_start;
                len_next   = next_len;
            end
            default:
            begin
                used_next  = used_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            start_reg <= '0;
            len_reg   <= LW'(RST_LEN);
        end
        else
        begin
            used_reg  <= used_next;
            start_reg <= start_next;
            len_reg   <= len_next;
        end
    end

    assign used  = used_reg;
    assign start = start_reg;
    assign len   = len_reg;

endmodule
